// File: rtl/rotary_speaker_speed_control_assert.svh
// Assertion macros shared by the rotary speaker speed control RTL
`ifndef ROTARY_SPEAKER_SPEED_CONTROL_ASSERT_SVH
`define ROTARY_SPEAKER_SPEED_CONTROL_ASSERT_SVH

// Invariant that must hold at every clock edge out of reset
`define RSSC_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Same-cycle implication
`define RSSC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RSSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rssc_pkg.sv
// Types, constants and the gamma cosine table of the rotary speaker speed control
package rssc_pkg;

  // Rotor model constants
  localparam int unsigned ACCEL_STEP        = 128;
  localparam int unsigned STOP_RATE         = 0;
  localparam int unsigned LIGHT_TABLE_DEPTH = 256;  // power of two, 64..4096
  localparam int unsigned LIGHT_DEPTH_LOG2  = $clog2(LIGHT_TABLE_DEPTH);

  // Field widths
  localparam int unsigned CTRL_W     = 7;
  localparam int unsigned CHAN_W     = 5;
  localparam int unsigned CCVAL_W    = 7;
  localparam int unsigned SPEED_W    = 2;
  localparam int unsigned LIGHT_W    = 8;
  localparam int unsigned RATE_W     = 15;
  localparam int unsigned KEEP_W     = 16;
  localparam int unsigned PHASE_W    = 17;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // One full rotor turn in phase units
  localparam logic [PHASE_W-1:0] TURN = PHASE_W'(65536);

  typedef enum logic [SPEED_W-1:0] {
    SPEED_STOP = 2'd0,
    SPEED_SLOW = 2'd1,
    SPEED_FAST = 2'd2
  } speed_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONTROLLER = 4'd0,
    CFG_CHANNEL    = 4'd1,
    CFG_VAL_STOP   = 4'd2,
    CFG_VAL_SLOW   = 4'd3,
    CFG_VAL_FAST   = 4'd4,
    CFG_SLOW_RATE  = 4'd5,
    CFG_FAST_RATE  = 4'd6,
    CFG_FRICTION   = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [CTRL_W-1:0]  controller_number;
    logic [CHAN_W-1:0]  midi_channel;
    logic [CCVAL_W-1:0] value_stopped;
    logic [CCVAL_W-1:0] value_slow;
    logic [CCVAL_W-1:0] value_fast;
    logic [RATE_W-1:0]  slow_rate;
    logic [RATE_W-1:0]  fast_rate;
    logic [KEEP_W-1:0]  friction_keep;
  } cfg_t;

  // Control from the speed logic to the rotor
  typedef struct packed {
    logic   step;   // commit one normal tick
    speed_e speed;  // speed of the request being processed
  } rotor_ctrl_t;

  // Status back from the rotor
  typedef struct packed {
    logic [PHASE_W-1:0] phase_q;  // stored phase
    logic [LIGHT_W-1:0] light;    // level for the phase this request leaves
  } rotor_stat_t;

  // First half of the gamma-2.4 cosine wave; entry i equals entry 256 - i
  localparam logic [LIGHT_W-1:0] HALF_WAVE [129] = '{
    8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd253, 8'd252, 8'd251,
    8'd249, 8'd248, 8'd246, 8'd244, 8'd242, 8'd240, 8'd237, 8'd235,
    8'd232, 8'd230, 8'd227, 8'd224, 8'd220, 8'd217, 8'd214, 8'd210,
    8'd206, 8'd203, 8'd199, 8'd195, 8'd191, 8'd187, 8'd183, 8'd178,
    8'd174, 8'd170, 8'd166, 8'd161, 8'd157, 8'd153, 8'd148, 8'd144,
    8'd140, 8'd135, 8'd131, 8'd126, 8'd122, 8'd118, 8'd114, 8'd109,
    8'd105, 8'd101, 8'd97,  8'd93,  8'd89,  8'd85,  8'd81,  8'd78,
    8'd74,  8'd71,  8'd67,  8'd64,  8'd60,  8'd57,  8'd54,  8'd51,
    8'd48,  8'd46,  8'd43,  8'd40,  8'd38,  8'd35,  8'd33,  8'd31,
    8'd29,  8'd27,  8'd25,  8'd23,  8'd21,  8'd20,  8'd18,  8'd17,
    8'd15,  8'd14,  8'd13,  8'd12,  8'd10,  8'd9,   8'd9,   8'd8,
    8'd7,   8'd6,   8'd5,   8'd5,   8'd4,   8'd4,   8'd3,   8'd3,
    8'd3,   8'd2,   8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0
  };

  // Quantize the phase to the table depth, then fold onto the half wave.
  // A parked phase of one full turn has zero low bits and reads entry 0.
  function automatic logic [LIGHT_W-1:0] light_of(logic [PHASE_W-1:0] phase);
    logic [15:0] q_al;
    logic [7:0]  idx;
    logic [7:0]  fold;
    q_al = phase[15:0] & (16'hFFFF << (16 - LIGHT_DEPTH_LOG2));
    idx  = q_al[15:8];
    if (idx > 8'd128) begin
      fold = 8'(9'd256 - {1'b0, idx});
    end else begin
      fold = idx;
    end
    return HALF_WAVE[fold];
  endfunction

endpackage

// File: rtl/rssc_if.sv
// Valid/ready channels carrying tick requests and results

// Tick request channel
interface rssc_in_if;
  logic valid;
  logic ready;
  logic action;
  logic speed_pressed;
  logic slow_mode;

  modport source (output valid, action, speed_pressed, slow_mode, input ready);
  modport sink   (input valid, action, speed_pressed, slow_mode, output ready);
endinterface

// Result channel
interface rssc_out_if;
  logic       valid;
  logic       ready;
  logic       cc_send;
  logic [6:0] cc_controller;
  logic [4:0] cc_channel;
  logic [6:0] cc_value;
  logic [1:0] speed_now;
  logic [7:0] light_level;

  modport source (output valid, cc_send, cc_controller, cc_channel, cc_value,
                  speed_now, light_level, input ready);
  modport sink   (input valid, cc_send, cc_controller, cc_channel, cc_value,
                  speed_now, light_level, output ready);
endinterface

// File: rtl/rssc_cfg_regs.sv
// Configuration register file of the rotary speaker speed control
module rssc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rssc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rssc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output rssc_pkg::cfg_t                   cfg_o
);
  import rssc_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CONTROLLER: cfg_d.controller_number = cfg_data_i[CTRL_W-1:0];
        CFG_CHANNEL:    cfg_d.midi_channel      = cfg_data_i[CHAN_W-1:0];
        CFG_VAL_STOP:   cfg_d.value_stopped     = cfg_data_i[CCVAL_W-1:0];
        CFG_VAL_SLOW:   cfg_d.value_slow        = cfg_data_i[CCVAL_W-1:0];
        CFG_VAL_FAST:   cfg_d.value_fast        = cfg_data_i[CCVAL_W-1:0];
        CFG_SLOW_RATE:  cfg_d.slow_rate         = cfg_data_i[RATE_W-1:0];
        CFG_FAST_RATE:  cfg_d.fast_rate         = cfg_data_i[RATE_W-1:0];
        CFG_FRICTION:   cfg_d.friction_keep     = cfg_data_i[KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.controller_number <= CTRL_W'(0);
      cfg_q.midi_channel      <= CHAN_W'(1);
      cfg_q.value_stopped     <= CCVAL_W'(0);
      cfg_q.value_slow        <= CCVAL_W'(64);
      cfg_q.value_fast        <= CCVAL_W'(127);
      cfg_q.slow_rate         <= RATE_W'(256);
      cfg_q.fast_rate         <= RATE_W'(2048);
      cfg_q.friction_keep     <= KEEP_W'(65000);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/rssc_rotor.sv
// Simulated rotor: rate ramp, friction, phase advance and indicator level
module rssc_rotor (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rssc_pkg::rotor_ctrl_t ctrl_i,
  input  rssc_pkg::cfg_t        cfg_i,
  output rssc_pkg::rotor_stat_t stat_o
);
  import rssc_pkg::*;

  logic [RATE_W-1:0]        rate_q, rate_d;
  logic [PHASE_W-1:0]       phase_q, phase_d;
  logic [RATE_W-1:0]        target;
  logic [RATE_W:0]          ramp_sum;
  logic [RATE_W-1:0]        ramped;
  logic [RATE_W+KEEP_W-1:0] product;
  logic [PHASE_W:0]         phase_sum;
  logic [PHASE_W-1:0]       phase_new;

  // Target rate for the speed
  always_comb begin
    case (ctrl_i.speed)
      SPEED_SLOW: target = cfg_i.slow_rate;
      SPEED_FAST: target = cfg_i.fast_rate;
      default:    target = RATE_W'(STOP_RATE);
    endcase
  end

  // Ramp up toward the target when below it, then apply the Q0.16 friction factor
  assign ramp_sum = {1'b0, rate_q} + (RATE_W+1)'(ACCEL_STEP);
  always_comb begin
    if (rate_q < target) begin
      ramped = (ramp_sum < {1'b0, target}) ? ramp_sum[RATE_W-1:0] : target;
    end else begin
      ramped = rate_q;
    end
  end
  assign product = ramped * cfg_i.friction_keep;
  assign rate_d  = product[RATE_W+KEEP_W-1:KEEP_W];

  // Phase advance; past a full turn it wraps, or parks when stopped and the rate is at or below the target
  assign phase_sum = {1'b0, phase_q} + (PHASE_W+1)'(rate_d);
  always_comb begin
    if (phase_sum > {1'b0, TURN}) begin
      if (ctrl_i.speed == SPEED_STOP && rate_d <= target) begin
        phase_new = TURN;
      end else begin
        phase_new = PHASE_W'(phase_sum - {1'b0, TURN});
      end
    end else begin
      phase_new = phase_sum[PHASE_W-1:0];
    end
  end

  assign phase_d = ctrl_i.step ? phase_new : phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= '0;
      phase_q <= '0;
    end else if (ctrl_i.step) begin
      rate_q  <= rate_d;
      phase_q <= phase_new;
    end
  end

  assign stat_o.phase_q = phase_q;
  assign stat_o.light   = light_of(phase_d);

endmodule

// File: rtl/rotary_speaker_speed_control.sv
// Rotary speaker speed control top level: request stage, speed logic, result stage.
// A request is held in the request register, then in the result register.
// Throughput: one request per cycle; the request register is reloaded whenever
// the result register is empty or being taken, so both sides can stall freely.
// Reset (rst_ni, asynchronous, active low) empties both stages, clears the fast
// flag, last speed, rotor rate and phase, and loads the register defaults.
module rotary_speaker_speed_control (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rssc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rssc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  rssc_in_if.sink                          item_in,
  rssc_out_if.source                       result_out
);
  import rssc_pkg::*;

  cfg_t        cfg;
  rotor_ctrl_t rotor_ctrl;
  rotor_stat_t rotor_stat;

  // Request stage
  logic in_valid_q;
  logic in_action_q, in_pressed_q, in_slow_q;
  logic advance;

  // Speed state
  logic   fast_q, fast_d;
  speed_e last_speed_q;
  speed_e speed;
  logic   send;
  logic [CCVAL_W-1:0] value;

  // Result stage
  logic               out_valid_q;
  logic               out_send_q;
  logic [CTRL_W-1:0]  out_ctrl_q;
  logic [CHAN_W-1:0]  out_chan_q;
  logic [CCVAL_W-1:0] out_value_q;
  speed_e             out_speed_q;
  logic [LIGHT_W-1:0] out_light_q;

  rssc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Handshake: the held request moves on when the result register is empty or being taken
  assign advance       = in_valid_q && (!out_valid_q || result_out.ready);
  assign item_in.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_in.ready) begin
      in_valid_q <= item_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_in.valid && item_in.ready) begin
      in_action_q  <= item_in.action;
      in_pressed_q <= item_in.speed_pressed;
      in_slow_q    <= item_in.slow_mode;
    end
  end

  // Speed decision; a forced resend ignores the button and keeps the speed and rotor state
  assign fast_d = in_action_q ? fast_q : (fast_q ^ in_pressed_q);

  always_comb begin
    if (fast_d) begin
      speed = SPEED_FAST;
    end else if (in_slow_q) begin
      speed = SPEED_SLOW;
    end else begin
      speed = SPEED_STOP;
    end
  end

  assign send = in_action_q || (speed != last_speed_q);

  always_comb begin
    case (speed)
      SPEED_FAST: value = cfg.value_fast;
      SPEED_SLOW: value = cfg.value_slow;
      default:    value = cfg.value_stopped;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q       <= 1'b0;
      last_speed_q <= SPEED_STOP;
    end else if (advance && !in_action_q) begin
      fast_q       <= fast_d;
      last_speed_q <= speed;
    end
  end

  // Rotor steps on normal ticks only
  assign rotor_ctrl.step  = advance && !in_action_q;
  assign rotor_ctrl.speed = speed;

  rssc_rotor u_rotor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (rotor_ctrl),
    .cfg_i  (cfg),
    .stat_o (rotor_stat)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || result_out.ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_send_q  <= send;
      out_ctrl_q  <= cfg.controller_number;
      out_chan_q  <= cfg.midi_channel;
      out_value_q <= value;
      out_speed_q <= speed;
      out_light_q <= rotor_stat.light;
    end
  end

  assign result_out.valid         = out_valid_q;
  assign result_out.cc_send       = out_send_q;
  assign result_out.cc_controller = out_ctrl_q;
  assign result_out.cc_channel    = out_chan_q;
  assign result_out.cc_value      = out_value_q;
  assign result_out.speed_now     = out_speed_q;
  assign result_out.light_level   = out_light_q;

`include "rotary_speaker_speed_control_assert.svh"

  // Phase never passes one full turn
  `RSSC_ASSERT_ALWAYS(a_phase_bound, rotor_stat.phase_q <= TURN,
                      "rotor phase beyond a full turn")
  // A stalled result blocks the request stage
  `RSSC_ASSERT_IMPL(a_stall_holds, out_valid_q && !result_out.ready, !advance,
                    "advance while stalled")
  // A forced resend leaves the rotor and the fast flag alone and always sends
  `RSSC_ASSERT_NEXT(a_force_keeps, advance && in_action_q,
                    $stable(rotor_stat.phase_q) && $stable(fast_q), "force changed state")
  `RSSC_ASSERT_NEXT(a_force_sends, advance && in_action_q, out_valid_q && out_send_q,
                    "force did not send")

endmodule
